/* rtl/core/rknpf_pkg.sv */
// Package for the red-keeping noir pixel filter: constants, item type, tables.
`timescale 1ns / 1ps
package rknpf_pkg;

  localparam int PIXEL_MAX     = 255;
  localparam int FRACTION_BITS = 16;

  localparam int F   = FRACTION_BITS;
  localparam int LW  = F + 1;   // values in [0, 1.0]
  localparam int DW  = F - 2;   // smoothstep numerator, below the span
  localparam int TW  = F + 2;   // blend targets, below 2.2
  localparam int RW  = F + 4;   // reciprocal of the span
  localparam int HW  = F + 2;   // output code thresholds
  localparam int Q30 = 30;

  localparam logic [63:0] ONE_V  = 64'd1 << F;
  localparam logic [63:0] MASK_V = ONE_V - 64'd1;
  localparam logic [63:0] K03_V  = (64'd3 << F) / 64'd10;
  localparam logic [63:0] K01_V  = (64'd1 << F) / 64'd10;
  localparam logic [63:0] K025_V = (64'd1 << F) / 64'd4;
  localparam logic [63:0] K11_V  = (64'd11 << F) / 64'd10;
  localparam logic [63:0] E045_V = (64'd45 << F) / 64'd100;
  localparam logic [63:0] E22_V  = (64'd22 << F) / 64'd10;
  localparam logic [63:0] SPAN_V = K025_V - K01_V;
  localparam logic [63:0] RECIP_V = (64'd1 << (2 * F)) / SPAN_V;

  localparam logic [F-1:0]  K03_C   = F'(K03_V);
  localparam logic [LW-1:0] K01_C   = LW'(K01_V);
  localparam logic [LW-1:0] K11_C   = LW'(K11_V);
  localparam logic [DW-1:0] SPAN_C  = DW'(SPAN_V);
  localparam logic [RW-1:0] RECIP_C = RW'(RECIP_V);
  localparam logic [LW-1:0] ONE_C   = LW'(ONE_V);

  // Word handed from the front to the back through the queue
  typedef struct packed {
    logic [LW-1:0] r;
    logic [LW-1:0] g;
    logic [LW-1:0] b;
    logic [F-1:0]  s;       // 1.1 * intensity
    logic [DW-1:0] d;       // red minus low edge
    logic          t_zero;  // at or below low edge
    logic          t_one;   // at or above high edge
  } rknpf_item_t;

  typedef logic [LW-1:0] lin_tbl_t [256];
  typedef logic [HW-1:0] thr_tbl_t [256];

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] nn;
    res   = 64'd0;
    bit_v = 64'd1 << 62;
    nn    = n;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > nn) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (nn >= res + bit_v) begin
          nn  = nn - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // log2 of n >= 1 in Q.F, fraction by repeated squaring
  function automatic logic [63:0] log2_int(logic [63:0] n);
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] acc;
    k = 64'd0;
    for (int i = 0; i < 40; i++) begin
      if (k < 64'd40 && (n >> (k + 64'd1)) != 64'd0) k = k + 64'd1;
    end
    m   = (k <= 64'(Q30)) ? (n << (64'(Q30) - k)) : (n >> (k - 64'(Q30)));
    acc = k << F;
    for (int i = F - 1; i >= 0; i--) begin
      m = (m * m) >> Q30;
      if (m >= (64'd2 << Q30)) begin
        m   = m >> 1;
        acc = acc | (64'd1 << i);
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] exp2_neg(logic [63:0] mag);
    logic [63:0] ip;
    logic [63:0] g;
    logic [63:0] pw;
    logic [63:0] root;
    logic [63:0] s;
    ip   = mag >> F;
    g    = ONE_V - (mag & MASK_V);
    pw   = 64'd1 << Q30;
    root = 64'd2 << Q30;
    for (int j = F; j >= 0; j--) begin
      if (g[j]) pw = (pw * root) >> Q30;
      root = isqrt64(root << Q30);
    end
    s = 64'(Q30 - F) + ip + 64'd1;
    if (ip > 64'd40 || s >= 64'd64) return 64'd0;
    return pw >> s;
  endfunction

  function automatic logic [63:0] pow_fx(logic [63:0] v, logic [63:0] e);
    logic [63:0] lg;
    lg = 64'd0;
    if (v == 64'd0) return 64'd0;
    if (v >= ONE_V) return ONE_V;
    lg = (64'(F) << F) - log2_int(v);
    return exp2_neg((lg * e) >> F);
  endfunction

  function automatic logic [63:0] lin_val(logic [63:0] c);
    logic [63:0] cc;
    cc = (c > 64'(PIXEL_MAX)) ? 64'(PIXEL_MAX) : c;
    return pow_fx((cc << F) / 64'(PIXEL_MAX), E045_V);
  endfunction

  function automatic logic [63:0] out_code(logic [63:0] v);
    logic [63:0] o;
    o = (64'(PIXEL_MAX) * pow_fx(v, E22_V)) >> F;
    if (o > 64'(PIXEL_MAX)) o = 64'(PIXEL_MAX);
    if (o > 64'd255) o = 64'd255;
    return o;
  endfunction

  function automatic lin_tbl_t build_lin_tbl();
    lin_tbl_t tb;
    for (int i = 0; i < 256; i++) tb[i] = LW'(lin_val(64'(i)));
    return tb;
  endfunction

  // Smallest blend value that reaches each output code
  function automatic thr_tbl_t build_thr_tbl();
    thr_tbl_t    tb;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    tb[0] = '0;
    for (int k = 1; k < 256; k++) begin
      if (out_code(ONE_V) < 64'(k)) begin
        tb[k] = HW'(ONE_V + 64'd1);
      end else begin
        lo = 64'd1;
        hi = ONE_V;
        for (int i = 0; i <= F + 1; i++) begin
          if (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (out_code(mid) >= 64'(k)) hi = mid;
            else lo = mid + 64'd1;
          end
        end
        tb[k] = HW'(lo);
      end
    end
    return tb;
  endfunction

  localparam lin_tbl_t LIN_TBL = build_lin_tbl();
  localparam thr_tbl_t THR_TBL = build_thr_tbl();

endpackage

/* rtl/core/rknpf_front.sv */
// Front part: linearizes the pixel, forms intensity and classifies the red edge.
`timescale 1ns / 1ps
module rknpf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic [7:0]           in_red_i,
  input  logic [7:0]           in_green_i,
  input  logic [7:0]           in_blue_i,
  output logic                 push_o,
  output rknpf_pkg::rknpf_item_t item_o
);
  import rknpf_pkg::*;

  logic          vld1_q, vld2_q;
  logic [LW-1:0] r1_q, g1_q, b1_q, r2_q, g2_q, b2_q;
  logic [F-1:0]  iv2_q;
  logic [F+2:0]  sum;
  logic [2*F+2:0] iv_prod;
  logic [LW-1:0] lo, diff;
  logic [2*F:0]  s_prod;

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= acc_i;
      vld2_q <= vld1_q;
    end
  end

  assign sum     = {2'b00, r1_q} + {2'b00, g1_q} + {2'b00, b1_q};
  assign iv_prod = sum * K03_C;

  // Table lookup, then intensity
  always_ff @(posedge clk_i) begin
    r1_q  <= LIN_TBL[in_red_i];
    g1_q  <= LIN_TBL[in_green_i];
    b1_q  <= LIN_TBL[in_blue_i];
    r2_q  <= r1_q;
    g2_q  <= g1_q;
    b2_q  <= b1_q;
    iv2_q <= iv_prod[2*F-1:F];
  end

  // Edge classification and intensity boost
  assign lo     = {1'b0, iv2_q} + K01_C;
  assign diff   = r2_q - lo;
  assign s_prod = iv2_q * K11_C;

  always_comb begin
    item_o.r      = r2_q;
    item_o.g      = g2_q;
    item_o.b      = b2_q;
    item_o.s      = s_prod[2*F-1:F];
    item_o.d      = diff[DW-1:0];
    item_o.t_zero = (r2_q <= lo);
    item_o.t_one  = (r2_q > lo) && (diff >= {2'b00, SPAN_C} + LW'(0));
  end

  assign push_o = vld2_q;

endmodule

/* rtl/core/rknpf_queue.sv */
// Two-word queue between the front and back parts.
`timescale 1ns / 1ps
module rknpf_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rknpf_pkg::rknpf_item_t wdata_i,
  input  logic                  pop_i,
  output logic                  vld_o,
  output logic                  full_o,
  output rknpf_pkg::rknpf_item_t rdata_o
);
  import rknpf_pkg::*;

  rknpf_item_t mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rd_q];
  assign vld_o   = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

/* rtl/core/rknpf_back.sv */
// Back part: red weight, blend and output coding.
`timescale 1ns / 1ps
module rknpf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mode_i,
  input  logic                  vld_i,
  input  rknpf_pkg::rknpf_item_t item_i,
  output logic                  pop_o,
  output logic                  done_o,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o
);
  import rknpf_pkg::*;

  localparam int NST = 15;

  logic [NST-1:0] vld_q;

  // S1
  logic [LW-1:0] q1_q, rk1_q, gk1_q, bk1_q;
  logic [F-1:0]  a1_q;
  logic [DW-1:0] d1_q;
  logic          tz1_q, to1_q;
  logic [DW+RW-1:0] q_prod;
  logic [2*F-1:0]   s_sq;
  logic [2*LW-1:0]  rk_prod;
  // S2
  logic [LW+DW-1:0] p2_q;
  logic [LW-1:0]    q2_q;
  logic [DW-1:0]    d2_q;
  logic             tz2_q, to2_q;
  logic [TW-1:0]    mix;
  logic [LW+DW-1:0] qs_prod;
  // S3..S5
  logic [LW-1:0]    t3_q, tt4_q, w5_q, w6_q;
  logic [F+1:0]     u4_q;
  logic [LW+DW:0]   rem;
  logic [2*LW-1:0]  t_sq;
  logic [LW+F+1:0]  w_prod;
  logic [F-1:0]     a_q [2:6];
  logic [TW-1:0]    tgt_q [2:5][3];
  // S6, S7
  logic             up6_q [3];
  logic [TW-1:0]    diff6_q [3];
  logic [LW-1:0]    v7_q [3];
  logic [LW+TW-1:0] stp [3];
  logic [TW-1:0]    val [3];
  // Code search
  logic [7:0]       k_q [8][3];
  logic [LW-1:0]    v_q [7][3];
  logic [7:0]       kin [8][3];
  logic [LW-1:0]    vin [8][3];
  logic [7:0]       cand [8][3];

  assign pop_o = vld_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[NST-2:0], vld_i};
  end

  assign q_prod  = item_i.d * RECIP_C;
  assign s_sq    = item_i.s * item_i.s;
  assign rk_prod = item_i.r * K11_C;

  // S1: reciprocal estimate, intensity square, boosted red
  always_ff @(posedge clk_i) begin
    q1_q  <= q_prod[F+LW-1:F];
    a1_q  <= s_sq[2*F-1:F];
    rk1_q <= rk_prod[F+LW-1:F];
    gk1_q <= item_i.g >> 1;
    bk1_q <= item_i.b >> 1;
    d1_q  <= item_i.d;
    tz1_q <= item_i.t_zero;
    to1_q <= item_i.t_one;
  end

  assign qs_prod = q1_q * SPAN_C;
  assign mix     = {1'b0, rk1_q} + {1'b0, gk1_q} + {1'b0, bk1_q};

  // S2: back-multiply, blend targets
  always_ff @(posedge clk_i) begin
    p2_q  <= qs_prod;
    q2_q  <= q1_q;
    d2_q  <= d1_q;
    tz2_q <= tz1_q;
    to2_q <= to1_q;
    a_q[2] <= a1_q;
    tgt_q[2][0] <= mode_i ? {1'b0, rk1_q} : mix;
    tgt_q[2][1] <= mode_i ? {1'b0, gk1_q} : mix;
    tgt_q[2][2] <= mode_i ? {1'b0, bk1_q} : mix;
  end

  assign rem    = {2'b00, d2_q, {F{1'b0}}} - {1'b0, p2_q};
  assign t_sq   = t3_q * t3_q;
  assign w_prod = tt4_q * u4_q;

  // S3: corrected quotient; S4: t squared; S5: weight
  always_ff @(posedge clk_i) begin
    if (tz2_q) t3_q <= '0;
    else if (to2_q) t3_q <= ONE_C;
    else if (rem >= (LW+DW+1)'(SPAN_C)) t3_q <= q2_q + LW'(1);
    else t3_q <= q2_q;
    tt4_q <= t_sq[F+LW-1:F];
    u4_q  <= (F+2)'(3 * ONE_V) - {t3_q, 1'b0};
    w5_q  <= w_prod[F+LW-1:F];
    w6_q  <= w5_q;
    for (int s = 3; s <= 6; s++) a_q[s] <= a_q[s-1];
    for (int s = 3; s <= 5; s++) tgt_q[s] <= tgt_q[s-1];
  end

  // S6: distance to target; S7: blend and clamp to one
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      stp[c] = w6_q * diff6_q[c];
      if (up6_q[c]) val[c] = {2'b00, a_q[6]} + stp[c][F+TW-1:F];
      else val[c] = {2'b00, a_q[6]} - stp[c][F+TW-1:F];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      up6_q[c]   <= tgt_q[5][c] >= {2'b00, a_q[5]};
      diff6_q[c] <= (tgt_q[5][c] >= {2'b00, a_q[5]}) ? tgt_q[5][c] - {2'b00, a_q[5]}
                                                      : {2'b00, a_q[5]} - tgt_q[5][c];
      v7_q[c]    <= (val[c] >= {1'b0, ONE_C}) ? ONE_C : val[c][LW-1:0];
    end
  end

  // Output code: binary search over the threshold table, one bit a stage
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      kin[0][c] = 8'd0;
      vin[0][c] = v7_q[c];
      for (int s = 1; s < 8; s++) begin
        kin[s][c] = k_q[s-1][c];
        vin[s][c] = v_q[s-1][c];
      end
      for (int s = 0; s < 8; s++) cand[s][c] = kin[s][c] | (8'h80 >> s);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 8; s++) begin
      for (int c = 0; c < 3; c++) begin
        k_q[s][c] <= (THR_TBL[cand[s][c]] <= {1'b0, vin[s][c]}) ? cand[s][c] : kin[s][c];
      end
    end
    for (int s = 0; s < 7; s++) begin
      for (int c = 0; c < 3; c++) begin
        v_q[s][c] <= vin[s][c];
      end
    end
  end

  assign done_o      = vld_q[NST-1];
  assign out_red_o   = k_q[7][0];
  assign out_green_o = k_q[7][1];
  assign out_blue_o  = k_q[7][2];

endmodule

/* rtl/core/red_keep_noir_pixel_filter_unit.sv */
// Top level of the red-keeping noir pixel filter.
// Usage:
//   Input channel: drive in_red_i, in_green_i, in_blue_i with start_i high;
//   the word is taken at a clock edge where start_i is high and busy_o low.
//   Output channel: done_o is high for one cycle with out_red_o, out_green_o
//   and out_blue_o; the receiver must take the word in that cycle.
//   Config: APB port, register colorize_mode at byte address 0, bit 0
//   (1 = tinted color, 0 = gray with red emphasis). pready is always high.
//   Write it only while no pixel is in flight.
// Path: a result follows its input word through two front stages,
//   the front/back queue, and fifteen back stages
//   (weight, blend, then an eight-step search for the output code).
// Throughput: one pixel per cycle; every stage is a fixed pipeline step
//   with no feedback, and busy_o only rises if the queue were full.
// Reset: rst_ni clears the pipeline valids, the queue and colorize_mode;
//   in-flight pixels are dropped.
// The receiver cannot stall, so the back part drains the queue every cycle.
`timescale 1ns / 1ps
module red_keep_noir_pixel_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        done_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rknpf_pkg::*;

  logic        colorize_q, colorize_d;
  logic        acc, push, q_vld, q_full, pop;
  rknpf_item_t f_item, q_item;

  // Config register
  assign pready     = 1'b1;
  assign colorize_d = (psel && penable && pwrite && !paddr[2]) ? pwdata[0] : colorize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) colorize_q <= 1'b0;
    else colorize_q <= colorize_d;
  end

  assign prdata = paddr[2] ? 32'd0 : {31'd0, colorize_q};

  assign busy_o = q_full;
  assign acc    = start_i && !busy_o;

  rknpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .push_o     (push),
    .item_o     (f_item)
  );

  rknpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (f_item),
    .pop_i   (pop),
    .vld_o   (q_vld),
    .full_o  (q_full),
    .rdata_o (q_item)
  );

  rknpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (colorize_q),
    .vld_i       (q_vld),
    .item_i      (q_item),
    .pop_o       (pop),
    .done_o      (done_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

endmodule

/* rtl/core/rknpf_checker.sv */
// Port-level checker for the pixel filter, bound to the top level.
`timescale 1ns / 1ps
module rknpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // Every taken word gives a result a fixed time later
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##18 done_o)
    else $error("result missing after accepted word");

  // No result without a word taken before
  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 18))
    else $error("result without accepted word");

  // Mode register reads back what was written
  a_cfg_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2])
      |=> (paddr[2] || prdata[0] == $past(pwdata[0])))
    else $error("mode readback mismatch");

  // The output side cannot stall, so the input never backs up
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

endmodule

bind red_keep_noir_pixel_filter_unit rknpf_checker u_chk (.*);

/* verif/tb.sv */
// Self-checking testbench for the red-keeping noir pixel filter.
`timescale 1ns / 1ps

class noir_scoreboard;
  logic [23:0] pending_q[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  function void note_pixel(logic [23:0] want);
    pending_q.push_back(want);
  endfunction

  function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [23:0] want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h %h %h", $time, r, g, b);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (want[23:16] !== r) begin
      $display("%0t: out_red expected %h actual %h", $time, want[23:16], r);
      errors++;
    end
    if (want[15:8] !== g) begin
      $display("%0t: out_green expected %h actual %h", $time, want[15:8], g);
      errors++;
    end
    if (want[7:0] !== b) begin
      $display("%0t: out_blue expected %h actual %h", $time, want[7:0], b);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int FB = 16;
  localparam int PMAX = 255;
  localparam logic [63:0] UNIT   = 64'd1 << FB;
  localparam logic [63:0] C_03   = (64'd3 << FB) / 64'd10;
  localparam logic [63:0] C_01   = (64'd1 << FB) / 64'd10;
  localparam logic [63:0] C_025  = (64'd1 << FB) / 64'd4;
  localparam logic [63:0] C_11   = (64'd11 << FB) / 64'd10;
  localparam logic [63:0] C_05   = 64'd1 << (FB - 1);
  localparam logic [63:0] EXP_LIN = (64'd45 << FB) / 64'd100;
  localparam logic [63:0] EXP_OUT = (64'd22 << FB) / 64'd10;
  localparam int LATENCY = 18;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic [7:0]  in_red_i = 0, in_green_i = 0, in_blue_i = 0;
  logic        done_o;
  logic [7:0]  out_red_o, out_green_o, out_blue_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  noir_scoreboard sb;
  logic        mode_shadow;
  bit          quiet_phase;

  red_keep_noir_pixel_filter_unit dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // integer square root, bit by bit
  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] acc, bv;
    acc = 0;
    bv = 64'd1 << 62;
    while (bv > n) bv = bv >> 2;
    while (bv != 0) begin
      if (n >= acc + bv) begin
        n = n - (acc + bv);
        acc = (acc >> 1) + bv;
      end else begin
        acc = acc >> 1;
      end
      bv = bv >> 2;
    end
    return acc;
  endfunction

  function automatic logic [63:0] fx_log2(logic [63:0] n);
    int unsigned k;
    logic [63:0] m, acc;
    k = 0;
    while (k < 40 && (n >> (k + 1)) != 0) k++;
    m = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
    acc = 64'(k) << FB;
    for (int i = FB - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        acc[i] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] fx_exp2_neg(logic [63:0] mag);
    logic [63:0] ip, frac, prod, rt, sh;
    ip = mag >> FB;
    frac = UNIT - (mag & (UNIT - 1));
    prod = 64'd1 << 30;
    rt = 64'd2 << 30;
    for (int j = FB; j >= 0; j--) begin
      if (frac[j]) prod = (prod * rt) >> 30;
      rt = root64(rt << 30);
    end
    if (ip > 40) return 0;
    sh = 64'(30 - FB) + ip + 1;
    if (sh >= 64) return 0;
    return prod >> sh;
  endfunction

  function automatic logic [63:0] fx_pow(logic [63:0] v, logic [63:0] e);
    logic [63:0] lg;
    if (v == 0) return 0;
    if (v >= UNIT) return UNIT;
    lg = (64'(FB) << FB) - fx_log2(v);
    return fx_exp2_neg((lg * e) >> FB);
  endfunction

  function automatic logic [63:0] fx_blend(logic [63:0] a, logic [63:0] b, logic [63:0] w);
    if (b >= a) return a + ((w * (b - a)) >> FB);
    return a - ((w * (a - b)) >> FB);
  endfunction

  function automatic logic [7:0] encode_channel(logic [63:0] v);
    logic [63:0] o;
    o = (64'(PMAX) * fx_pow(v, EXP_OUT)) >> FB;
    if (o > 64'(PMAX)) o = 64'(PMAX);
    if (o > 64'd255) o = 64'd255;
    return o[7:0];
  endfunction

  function automatic logic [63:0] decode_channel(logic [7:0] c);
    return fx_pow((64'(c) << FB) / 64'(PMAX), EXP_LIN);
  endfunction

  // expected output pixel, packed red/green/blue
  function automatic logic [23:0] noir_pixel(logic [7:0] ri, logic [7:0] gi, logic [7:0] bi,
                                             logic tinted);
    logic [63:0] r, g, b, iv, lo, span, t, tt, w, s, mix;
    logic [7:0]  o;
    r = decode_channel(ri);
    g = decode_channel(gi);
    b = decode_channel(bi);
    iv = (C_03 * (r + g + b)) >> FB;
    lo = iv + C_01;
    span = C_025 - C_01;
    if (r <= lo) t = 0;
    else if (r - lo >= span) t = UNIT;
    else t = ((r - lo) << FB) / span;
    tt = (t * t) >> FB;
    w = (tt * (3 * UNIT - 2 * t)) >> FB;
    s = (iv * C_11) >> FB;
    iv = (s * s) >> FB;
    if (tinted) begin
      return {encode_channel(fx_blend(iv, (r * C_11) >> FB, w)),
              encode_channel(fx_blend(iv, (g * C_05) >> FB, w)),
              encode_channel(fx_blend(iv, (b * C_05) >> FB, w))};
    end
    mix = ((r * C_11) >> FB) + ((b * C_05) >> FB) + ((g * C_05) >> FB);
    o = encode_channel(fx_blend(iv, mix, w));
    return {o, o, o};
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_pixel(out_red_o, out_green_o, out_blue_o);
  end

  task automatic write_mode(logic val);
    @(negedge clk_i);
    psel = 1; pwrite = 1; penable = 0; paddr = 0; pwdata = {$urandom} & ~32'd1 | 32'(val);
    @(negedge clk_i);
    penable = 1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    mode_shadow = val;
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    start_i = 1;
    in_red_i = r; in_green_i = g; in_blue_i = b;
    do @(posedge clk_i); while (busy_o);
    sb.note_pixel(noir_pixel(r, g, b, mode_shadow));
    @(negedge clk_i);
    start_i = 0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic directed_set();
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(200, 60, 60);
    send_pixel(120, 80, 80);
    send_pixel(1, 1, 1);
    send_pixel(128, 127, 128);
    send_pixel(170, 85, 85);
  endtask

  task automatic random_set(int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      // bias toward reds near the smoothstep band
      if ($urandom_range(0, 2) == 0) begin
        g = 8'($urandom_range(0, r)); b = 8'($urandom_range(0, r));
      end
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    sb = new();
    mode_shadow = 0;
    quiet_phase = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    directed_set();
    drain();
    write_mode(1);
    directed_set();
    random_set(600);
    drain();
    write_mode(0);
    random_set(600);
    drain();
    write_mode(1);
    quiet_phase = 1;
    random_set(630);
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule
